// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

// ----- design/bid_pkg.sv -----
// Package with the command and status codes and the cell control type of the deque.
package bid_pkg;

	localparam int FUNC_W  = 3;
	localparam int COUNT_W = 5;
	localparam int DATA_W  = 32;
	localparam int STAT_W  = 2;

	localparam logic [COUNT_W-1:0] MAX_ENTRIES_RST = 5'd16;

	// The unused selector changes nothing and answers ok.
	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_BACK  = 3'd0,
		FN_PUSH_FRONT = 3'd1,
		FN_INSERT     = 3'd2,
		FN_POP_FRONT  = 3'd3,
		FN_REMOVE     = 3'd4,
		FN_REVERSE    = 3'd5,
		FN_POP_BACK   = 3'd6,
		FN_UNUSED     = 3'd7
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Shift command broadcast to every cell in the row.
	typedef struct packed {
		logic ins;
		logic rem;
	} shift_ctrl_t;

endpackage

// ----- design/bid_ifs.sv -----
// Valid/ready channel interfaces for deque commands and responses.
interface bid_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [bid_pkg::FUNC_W-1:0]         func;
	logic [bid_pkg::COUNT_W-1:0]        position;
	logic signed [bid_pkg::DATA_W-1:0]  value;

	modport source (output valid, func, position, value, input ready);
	modport sink (input valid, func, position, value, output ready);
endinterface

interface bid_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [bid_pkg::STAT_W-1:0]         status;
	logic signed [bid_pkg::DATA_W-1:0]  removed_value;
	logic [bid_pkg::COUNT_W-1:0]        entry_count;

	modport source (output valid, status, removed_value, entry_count, input ready);
	modport sink (input valid, status, removed_value, entry_count, output ready);
endinterface

// ----- design/bid_cell.sv -----
// One storage cell of the deque row, shifting toward either neighbor on command.
module bid_cell #(
	parameter int IDX = 0,
	parameter int PW  = 5
) (
	input  logic                         clk,
	input  bid_pkg::shift_ctrl_t         ctrl,
	input  logic [PW-1:0]                idx,
	input  logic [bid_pkg::DATA_W-1:0]   new_value,
	input  logic [bid_pkg::DATA_W-1:0]   below_data,
	input  logic [bid_pkg::DATA_W-1:0]   above_data,
	output logic [bid_pkg::DATA_W-1:0]   data
);

	logic [bid_pkg::DATA_W-1:0] data_q;
	logic                       at_idx;
	logic                       past_idx;

	assign at_idx   = (idx == PW'(IDX));
	assign past_idx = (idx < PW'(IDX));
	assign data     = data_q;

	// Insert opens a gap at idx by moving later cells up; remove closes it from above.
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (at_idx) begin
				data_q <= new_value;
			end else if (past_idx) begin
				data_q <= below_data;
			end
		end else if (ctrl.rem) begin
			if (at_idx || past_idx) begin
				data_q <= above_data;
			end
		end
	end

endmodule

// ----- design/bounded_indexed_deque.sv -----
// Bounded deque with indexed insert and remove built as a row of shifting cells.
// The response for a command is registered and appears in the cycle after it is accepted.
// Throughput: one command per cycle for every command; only a held, untaken response stalls input.
// Reverse costs nothing: it flips a direction flag that remaps logical to physical positions.
// Reset clears the entry count, the direction flag and the response valid, and sets the limit to 16.
// Cell contents are not reset; only cells below the count are ever read.
module bounded_indexed_deque #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bid_pkg::COUNT_W-1:0]   cfg_wdata,
	bid_cmd_if.sink                       cmd,
	bid_rsp_if.source                     rsp
);

	// Width of the physical cell index, and of the index broadcast to the cells.
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW        = (IDX_W > bid_pkg::COUNT_W) ? IDX_W : bid_pkg::COUNT_W;
	// The count field is five bits wide, so the usable depth never exceeds 31.
	localparam int DEPTH_CAP = (DEPTH > 31) ? 31 : DEPTH;

	localparam logic [bid_pkg::COUNT_W-1:0] ONE  = bid_pkg::COUNT_W'(1);
	localparam logic [bid_pkg::COUNT_W-1:0] ZERO = '0;

	// Architectural state: number of entries, direction flag and the entry limit.
	logic [bid_pkg::COUNT_W-1:0] count_q;
	logic                        rev_q;
	logic [bid_pkg::COUNT_W-1:0] max_entries_q;

	// Response register, which decouples the command side from a stalled consumer.
	logic                               rsp_valid_q;
	logic [bid_pkg::STAT_W-1:0]         rsp_status_q;
	logic [bid_pkg::DATA_W-1:0]         rsp_removed_q;
	logic [bid_pkg::COUNT_W-1:0]        rsp_count_q;

	// Command decode.
	logic                        fire;
	logic                        ins_req;
	logic                        rem_req;
	logic                        flip;
	logic                        do_ins;
	logic                        do_rem;
	bid_pkg::status_t            status;
	logic [bid_pkg::COUNT_W-1:0] lpos;
	logic [bid_pkg::COUNT_W-1:0] phys;
	logic [bid_pkg::COUNT_W-1:0] cap;
	logic [PW-1:0]               cell_idx;
	logic [bid_pkg::DATA_W-1:0]  taken;

	bid_pkg::shift_ctrl_t        ctrl;
	logic [bid_pkg::DATA_W-1:0]  cell_data [DEPTH];

	assign fire      = cmd.valid && cmd.ready;
	assign cmd.ready = !rsp_valid_q || rsp.ready;

	// Effective capacity is the programmed limit clamped to the number of cells.
	assign cap = (max_entries_q < bid_pkg::COUNT_W'(DEPTH_CAP)) ?
		max_entries_q : bid_pkg::COUNT_W'(DEPTH_CAP);

	// Translate the command into a logical position and check it against the
	// count and the capacity. The empty check ranks above the position check for
	// removals, and the position check ranks above the full check for inserts.
	always_comb begin
		ins_req = 1'b0;
		rem_req = 1'b0;
		flip    = 1'b0;
		lpos    = ZERO;
		do_ins  = 1'b0;
		do_rem  = 1'b0;
		status  = bid_pkg::ST_OK;
		case (cmd.func)
			bid_pkg::FN_PUSH_BACK: begin
				ins_req = 1'b1;
				lpos    = count_q;
			end
			bid_pkg::FN_PUSH_FRONT: begin
				ins_req = 1'b1;
			end
			bid_pkg::FN_INSERT: begin
				ins_req = 1'b1;
				lpos    = cmd.position;
			end
			bid_pkg::FN_POP_FRONT: begin
				rem_req = 1'b1;
			end
			bid_pkg::FN_REMOVE: begin
				rem_req = 1'b1;
				lpos    = cmd.position;
			end
			bid_pkg::FN_REVERSE: begin
				flip = 1'b1;
			end
			bid_pkg::FN_POP_BACK: begin
				rem_req = 1'b1;
				lpos    = count_q - ONE;
			end
			default: begin
			end
		endcase
		if (ins_req) begin
			if (lpos > count_q) begin
				status = bid_pkg::ST_RANGE;
			end else if (count_q >= cap) begin
				status = bid_pkg::ST_FULL;
			end else begin
				do_ins = 1'b1;
			end
		end
		if (rem_req) begin
			if (count_q == ZERO) begin
				status = bid_pkg::ST_EMPTY;
			end else if (lpos >= count_q) begin
				status = bid_pkg::ST_RANGE;
			end else begin
				do_rem = 1'b1;
			end
		end
	end

	// In reversed order logical position p sits at physical cell count-p for an
	// insert (the gap lands after the existing entry) and count-1-p for a removal.
	assign phys = rev_q ? (count_q - lpos - (rem_req ? ONE : ZERO)) : lpos;

	assign cell_idx = PW'(phys);
	assign ctrl.ins = fire && do_ins;
	assign ctrl.rem = fire && do_rem;

	// The row of cells. Each cell sees its two neighbors; the first cell's lower
	// neighbor is never selected and the last cell keeps its own data on removal.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [bid_pkg::DATA_W-1:0] below;
		logic [bid_pkg::DATA_W-1:0] above;
		if (g == 0) begin : g_first
			assign below = cmd.value;
		end else begin : g_mid_lo
			assign below = cell_data[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign above = cell_data[g];
		end else begin : g_mid_hi
			assign above = cell_data[g+1];
		end
		bid_cell #(
			.IDX (g),
			.PW  (PW)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.idx        (cell_idx),
			.new_value  (cmd.value),
			.below_data (below),
			.above_data (above),
			.data       (cell_data[g])
		);
	end

	// A valid removal always addresses a cell below the count, so the low bits suffice.
	assign taken = do_rem ? cell_data[cell_idx[IDX_W-1:0]] : '0;

	// Control state: count, direction, limit and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= ZERO;
			rev_q         <= 1'b0;
			max_entries_q <= bid_pkg::MAX_ENTRIES_RST;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_entries_q <= cfg_wdata;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
				if (do_ins) begin
					count_q <= count_q + ONE;
				end else if (do_rem) begin
					count_q <= count_q - ONE;
				end
				if (flip) begin
					rev_q <= !rev_q;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload, captured with each accepted transaction.
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_status_q  <= status;
			rsp_removed_q <= taken;
			if (do_ins) begin
				rsp_count_q <= count_q + ONE;
			end else if (do_rem) begin
				rsp_count_q <= count_q - ONE;
			end else begin
				rsp_count_q <= count_q;
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.removed_value = rsp_removed_q;
	assign rsp.entry_count   = rsp_count_q;

endmodule

// ----- design/bid_checker.sv -----
// Port-level assertions for the deque, bound to the top level.
`include "assert_macros.svh"

module bid_checker #(
	parameter int DEPTH = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cmd_valid,
	input logic                          cmd_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [bid_pkg::STAT_W-1:0]    status,
	input logic [bid_pkg::DATA_W-1:0]    removed_value,
	input logic [bid_pkg::COUNT_W-1:0]   entry_count
);

	// A response stays offered until it is taken.
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	// Every accepted command yields a response in the following cycle.
	`ASSERT_NEXT(a_rsp_follows, clk, arst_n, cmd_valid && cmd_ready, rsp_valid)

	// A failed command never reports a taken value.
	`ASSERT_SAME(a_fail_zero, clk, arst_n, rsp_valid && (status != bid_pkg::ST_OK),
		removed_value == '0)

	// An empty answer only comes from an empty deque.
	`ASSERT_SAME(a_empty_count, clk, arst_n, rsp_valid && (status == bid_pkg::ST_EMPTY),
		entry_count == '0)

	// The count never exceeds the number of cells.
	`ASSERT_SAME(a_count_bound, clk, arst_n, rsp_valid, 32'(entry_count) <= DEPTH)

endmodule

bind bounded_indexed_deque bid_checker #(
	.DEPTH (DEPTH)
) u_bid_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.status        (rsp.status),
	.removed_value (rsp.removed_value),
	.entry_count   (rsp.entry_count)
);

// ----- sim/tb_bounded_indexed_deque.sv -----
// Self-checking testbench for the bounded indexed deque with random handshake pressure.
module tb_bounded_indexed_deque;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	// Cycles with no transaction on either channel before the run is declared hung.
	localparam int STALL_LIMIT = 2000;

	// One response as the deque should answer it.
	typedef struct {
		bid_pkg::status_t   status;
		logic signed [31:0] removed;
		logic [4:0]         count;
	} deque_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [bid_pkg::COUNT_W-1:0] cfg_wdata;

	bid_cmd_if cmd_ch();
	bid_rsp_if rsp_ch();

	bounded_indexed_deque #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch)
	);

	// Shadow copy of the deque contents, its count and the entry limit register.
	logic signed [31:0] shadow_cells [DEPTH];
	int shadow_count = 0;
	int shadow_limit = 16;

	// Responses predicted at command acceptance, oldest first.
	deque_result_t pending_results [$];

	int error_count = 0;
	// Idle percentages for the command sender and the response receiver.
	int tx_gap_pct = 0;
	int rx_stall_pct = 0;
	// A long receiver hold-off requested by a test; the receiver process counts it down.
	int hold_request = 0;

	// 4 ns clock period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Inserts a value at a logical position, shifting the later entries back by one.
	// The position check wins over the full check.
	function automatic bid_pkg::status_t shadow_insert(int pos, logic signed [31:0] val,
			int cap);
		if (pos > shadow_count)
			return bid_pkg::ST_RANGE;
		if (shadow_count >= cap)
			return bid_pkg::ST_FULL;
		for (int i = shadow_count; i > pos; i--)
			shadow_cells[i] = shadow_cells[i-1];
		shadow_cells[pos] = val;
		shadow_count++;
		return bid_pkg::ST_OK;
	endfunction

	// Takes out the entry at a logical position; an empty deque wins over a bad position.
	function automatic bid_pkg::status_t shadow_remove(int pos,
			output logic signed [31:0] taken);
		taken = '0;
		if (shadow_count == 0)
			return bid_pkg::ST_EMPTY;
		if (pos >= shadow_count)
			return bid_pkg::ST_RANGE;
		taken = shadow_cells[pos];
		for (int i = pos; i + 1 < shadow_count; i++)
			shadow_cells[i] = shadow_cells[i+1];
		shadow_count--;
		return bid_pkg::ST_OK;
	endfunction

	// Applies one command to the shadow deque and returns the response it should give.
	function automatic deque_result_t deque_apply(logic [2:0] f, logic [4:0] pos,
			logic signed [31:0] val);
		deque_result_t r;
		logic signed [31:0] swap;
		int cap;
		r.status = bid_pkg::ST_OK;
		r.removed = '0;
		// The limit register is clamped to the physical depth.
		cap = (shadow_limit < DEPTH) ? shadow_limit : DEPTH;
		case (f)
			bid_pkg::FN_PUSH_BACK:  r.status = shadow_insert(shadow_count, val, cap);
			bid_pkg::FN_PUSH_FRONT: r.status = shadow_insert(0, val, cap);
			bid_pkg::FN_INSERT:     r.status = shadow_insert(int'(pos), val, cap);
			bid_pkg::FN_POP_FRONT:  r.status = shadow_remove(0, r.removed);
			bid_pkg::FN_REMOVE:     r.status = shadow_remove(int'(pos), r.removed);
			bid_pkg::FN_POP_BACK: begin
				if (shadow_count == 0)
					r.status = bid_pkg::ST_EMPTY;
				else
					r.status = shadow_remove(shadow_count - 1, r.removed);
			end
			bid_pkg::FN_REVERSE: begin
				for (int lo = 0; lo < shadow_count / 2; lo++) begin
					swap = shadow_cells[lo];
					shadow_cells[lo] = shadow_cells[shadow_count-1-lo];
					shadow_cells[shadow_count-1-lo] = swap;
				end
			end
			// The unused selector leaves everything alone and answers ok.
			default: ;
		endcase
		if (r.status != bid_pkg::ST_OK)
			r.removed = '0;
		r.count = shadow_count[4:0];
		return r;
	endfunction

	// Offers one command, possibly after a random gap, and records its predicted response
	// once the transaction completes. Valid stays high afterwards until the next call or drain.
	task automatic send_cmd(input logic [2:0] f, input logic [4:0] pos,
			input logic signed [31:0] val);
		deque_result_t predicted;
		@(negedge clk);
		if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.func <= f;
		cmd_ch.position <= pos;
		cmd_ch.value <= val;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		predicted = deque_apply(f, pos, val);
		pending_results.push_back(predicted);
	endtask

	// Stops offering commands and waits until every predicted response has come back.
	task automatic drain();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// The bench then waits for the response register to settle before the block counts as idle.
		repeat (2) @(posedge clk);
	endtask

	// Writes the entry limit register while the deque is idle.
	task automatic set_limit(input int limit);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= limit[bid_pkg::COUNT_W-1:0];
		@(posedge clk);
		shadow_limit = limit;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Picks a data value, leaning on the signed extremes.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Empty-deque corner cases, the first insert, one-entry reverse and position checks.
	task automatic test_empty_and_positions();
		send_cmd(bid_pkg::FN_POP_FRONT, 5'd0, 32'sd0);
		send_cmd(bid_pkg::FN_POP_BACK, 5'd31, 32'sd0);
		send_cmd(bid_pkg::FN_REMOVE, 5'd0, 32'sd0);
		send_cmd(bid_pkg::FN_REVERSE, 5'd0, 32'sd0);
		send_cmd(bid_pkg::FN_UNUSED, 5'd31, -32'sd1);
		// Inserting into an empty deque past the end is out of range, at zero it is fine.
		send_cmd(bid_pkg::FN_INSERT, 5'd1, 32'sd5);
		send_cmd(bid_pkg::FN_INSERT, 5'd0, 32'sh8000_0000);
		send_cmd(bid_pkg::FN_REVERSE, 5'd0, 32'sd0);
		send_cmd(bid_pkg::FN_PUSH_BACK, 5'd16, 32'sh7fff_ffff);
		send_cmd(bid_pkg::FN_PUSH_FRONT, 5'd0, -32'sd1);
		send_cmd(bid_pkg::FN_INSERT, 5'd1, 32'sh5555_5555);
		send_cmd(bid_pkg::FN_INSERT, 5'd31, 32'shaaaa_aaaa);
		// A remove at a position equal to the count is out of range.
		send_cmd(bid_pkg::FN_REMOVE, 5'd4, 32'sd0);
		send_cmd(bid_pkg::FN_REMOVE, 5'd31, 32'sd0);
		send_cmd(bid_pkg::FN_REVERSE, 5'd0, 32'sd0);
		send_cmd(bid_pkg::FN_POP_BACK, 5'd0, 32'sd0);
		send_cmd(bid_pkg::FN_REMOVE, 5'd1, 32'sd0);
		send_cmd(bid_pkg::FN_POP_FRONT, 5'd0, 32'sd0);
		drain();
	endtask

	// Limit register settings: small, zero, above the depth, and lowered below the count.
	task automatic test_limit_settings();
		set_limit(2);
		send_cmd(bid_pkg::FN_PUSH_BACK, 5'd0, 32'sd11);
		send_cmd(bid_pkg::FN_PUSH_FRONT, 5'd0, 32'sd12);
		// Bad position is reported ahead of full.
		send_cmd(bid_pkg::FN_INSERT, 5'd9, 32'sd13);
		send_cmd(bid_pkg::FN_INSERT, 5'd1, 32'sd13);
		set_limit(0);
		send_cmd(bid_pkg::FN_PUSH_BACK, 5'd0, 32'sd14);
		send_cmd(bid_pkg::FN_POP_BACK, 5'd0, 32'sd0);
		set_limit(31);
		for (int i = 0; i < 5; i++)
			send_cmd(bid_pkg::FN_PUSH_BACK, 5'(i), pick_value());
		// Entries above the new limit stay until enough of them are removed.
		set_limit(3);
		send_cmd(bid_pkg::FN_PUSH_FRONT, 5'd0, 32'sd15);
		send_cmd(bid_pkg::FN_POP_FRONT, 5'd0, 32'sd0);
		send_cmd(bid_pkg::FN_POP_FRONT, 5'd0, 32'sd0);
		send_cmd(bid_pkg::FN_PUSH_BACK, 5'd0, 32'sd16);
		send_cmd(bid_pkg::FN_PUSH_BACK, 5'd0, 32'sd17);
		drain();
	endtask

	// The receiver holds off for a long stretch while commands keep coming, so the
	// response register fills and the command channel stalls; the deque also fills up.
	task automatic test_backpressure();
		set_limit(16);
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		hold_request = 60;
		for (int i = 0; i < 24; i++)
			send_cmd(bid_pkg::FN_PUSH_BACK, 5'($urandom_range(0, 31)), pick_value());
		// Sender pauses here until every response has arrived.
		drain();
	endtask

	// Random traffic, mostly legal commands that keep the deque between empty and full,
	// with a share of bad positions and the unused selector mixed in.
	task automatic test_random_traffic(input int items, input int limit, input int gap_pct,
			input int stall_pct);
		logic [2:0] f;
		logic [4:0] pos;
		int cap;
		int roll;
		set_limit(limit);
		tx_gap_pct = gap_pct;
		rx_stall_pct = stall_pct;
		cap = (limit < DEPTH) ? limit : DEPTH;
		for (int n = 0; n < items; n++) begin
			roll = $urandom_range(0, 99);
			pos = 5'($urandom_range(0, 31));
			if (roll < 4) begin
				f = bid_pkg::FN_UNUSED;
			end else if (roll < 10) begin
				f = bid_pkg::FN_REVERSE;
			end else if ($urandom_range(0, 99) < ((shadow_count * 2 < cap) ? 65 : 35)) begin
				case ($urandom_range(0, 2))
					0: f = bid_pkg::FN_PUSH_BACK;
					1: f = bid_pkg::FN_PUSH_FRONT;
					default: begin
						f = bid_pkg::FN_INSERT;
						if ($urandom_range(0, 7) != 0)
							pos = 5'($urandom_range(0, shadow_count));
					end
				endcase
			end else begin
				case ($urandom_range(0, 2))
					0: f = bid_pkg::FN_POP_FRONT;
					1: f = bid_pkg::FN_POP_BACK;
					default: begin
						f = bid_pkg::FN_REMOVE;
						if (shadow_count > 0 && $urandom_range(0, 7) != 0)
							pos = 5'($urandom_range(0, shadow_count - 1));
					end
				endcase
			end
			send_cmd(f, pos, pick_value());
		end
	endtask

	// Stimulus sequence.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.func = '0;
		cmd_ch.position = '0;
		cmd_ch.value = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		tx_gap_pct = 20;
		rx_stall_pct = 20;
		test_empty_and_positions();
		test_limit_settings();
		test_backpressure();
		test_random_traffic(200, 16, 20, 20);
		test_random_traffic(150, 5, 0, 30);
		test_random_traffic(200, 31, 30, 0);
		test_random_traffic(150, 1, 10, 10);
		test_random_traffic(100, 9, 15, 15);
		// The last part runs with no idling on either side.
		test_random_traffic(200, 16, 0, 0);

		drain();
		repeat (5) @(posedge clk);
		if (error_count == 0)
			$display("bounded_indexed_deque: match");
		else
			$display("bounded_indexed_deque: mismatch");
		$finish;
	end

	// Response receiver: random stall bursts, plus any long hold-off that a test asks for,
	// counted down here.
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b1;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				stall_left = hold_request - 1;
				hold_request = 0;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
				stall_left = $urandom_range(1, 10) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Response checker: every response transaction is matched against the oldest prediction.
	always @(posedge clk) begin
		deque_result_t exp_r;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: response with none expected: status %0d removed %0d count %0d",
					$time, rsp_ch.status, rsp_ch.removed_value, rsp_ch.entry_count);
			end else begin
				exp_r = pending_results.pop_front();
				if (rsp_ch.status !== exp_r.status || rsp_ch.removed_value !== exp_r.removed ||
						rsp_ch.entry_count !== exp_r.count) begin
					error_count++;
					$display("%0t: expected status %0d removed %0d count %0d, got %0d %0d %0d",
						$time, exp_r.status, exp_r.removed, exp_r.count,
						rsp_ch.status, rsp_ch.removed_value, rsp_ch.entry_count);
				end
			end
		end
	end

	// Watchdog: counts cycles in which no transaction happens on either channel.
	always @(posedge clk) begin
		int quiet_cycles;
		if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("bounded_indexed_deque: mismatch");
				$finish;
			end
		end
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/bid_pkg.sv
design/bid_ifs.sv
design/bid_cell.sv
design/bounded_indexed_deque.sv
design/bid_checker.sv
sim/tb_bounded_indexed_deque.sv
